>>> hw/rtl/sge_pkg.sv
// ----------------------------------------------------------------------------
// sge_pkg: shared types and constants for the sRGB encoder
// Pixel word type, linear-segment limits, stage control and the
// elaboration-time helpers that build the curve node table.
// ----------------------------------------------------------------------------
package sge_pkg;

    localparam int PIX_W = 16;

    typedef logic [PIX_W-1:0] pix_t;

    // Stage control handed from the top level to each channel
    typedef struct packed {
        logic load;     // input word accepted this cycle
        logic advance;  // stage 1 holds a word, move it to the result register
    } stage_ctl_t;

    // Linear segment: codes 0..LIN_LIMIT use 12.92*x
    localparam pix_t LIN_LIMIT = 16'd205;
    localparam pix_t LIN_MAX   = 16'd2649;   // largest linear-segment output
    localparam int   LIN_MUL   = 323;
    localparam int   LIN_RND   = 12;
    localparam int   LIN_DEN   = 25;

    // Curve node math, Q0.50 power term scaled by 211/200 minus 11/200
    localparam logic [63:0] NODE_GAIN = 64'd211;
    localparam logic [63:0] NODE_OFS  = 64'd11 << 50;
    localparam logic [63:0] NODE_RND  = 64'd100 << 34;
    localparam logic [63:0] NODE_DIV  = 64'd200 << 34;
    localparam logic [63:0] NODE_SAT  = 64'd65535;

    // floor(cbrt(v)), v < 2^63
    function automatic logic [63:0] root3(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = 64'd1 << 21;
        while ((hi - lo) > 64'd1)
        begin
            mid = (lo + hi) >> 1;
            if ((mid * mid * mid) <= v)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // floor(sqrt(v)), v < 2^62
    function automatic logic [63:0] root2(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = 64'd1 << 31;
        while ((hi - lo) > 64'd1)
        begin
            mid = (lo + hi) >> 1;
            if ((mid * mid) <= v)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Curve node for x = uq / 2^48; uq is worked out by the caller
    function automatic pix_t node_value(input logic [63:0] uq);
        logic [63:0] u;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] f;
        logic [63:0] pos;
        logic [63:0] q;
        u   = uq << 12;             // Q0.60
        c   = root3(u);             // x^(1/3), Q0.20
        s   = root2(c << 40);       // x^(1/6), Q0.30
        f   = root2(s << 30);       // x^(1/12), Q0.30
        pos = NODE_GAIN * (c * f);  // x^(5/12) in Q0.50, times 211
        if (pos <= NODE_OFS)
        begin
            q = 64'd0;
        end
        else
        begin
            q = (pos - NODE_OFS + NODE_RND) / NODE_DIV;
            if (q > NODE_SAT)
            begin
                q = NODE_SAT;
            end
        end
        return q[PIX_W-1:0];
    endfunction

endpackage

>>> hw/rtl/sge_channel.sv
// ----------------------------------------------------------------------------
// sge_channel: one color channel of the sRGB encoder
// Stage 1 registers the table reads (linear segment value or the two curve
// nodes around x) and the fraction; stage 2 interpolates and saturates.
// ----------------------------------------------------------------------------
module sge_channel #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                   clk,
    input  sge_pkg::stage_ctl_t    ctl,
    input  sge_pkg::pix_t          lin,
    output sge_pkg::pix_t          enc
);
    import sge_pkg::*;

    localparam int NA_W = $clog2(TABLE_ENTRIES + 1);
    localparam int T_W  = PIX_W + NA_W;

    // Constant tables
    pix_t node_rom [TABLE_ENTRIES+1];
    pix_t lin_rom  [256];

    for (genvar g = 0; g <= TABLE_ENTRIES; g++)
    begin : g_node
        localparam logic [63:0] UQ   = (64'(g) << 48) / TABLE_ENTRIES;
        localparam pix_t        NODE = node_value(UQ);
        assign node_rom[g] = NODE;
    end

    for (genvar g = 0; g < 256; g++)
    begin : g_lin
        localparam pix_t LV = PIX_W'((LIN_MUL * g + LIN_RND) / LIN_DEN);
        assign lin_rom[g] = LV;
    end

    // Node address and fraction: t = x * TABLE_ENTRIES
    logic [T_W-1:0]  t;
    logic [NA_W-1:0] idx;
    logic [NA_W-1:0] idx_hi;
    logic            is_lin;

    assign t      = T_W'(lin) * T_W'(TABLE_ENTRIES);
    assign idx    = t[T_W-1:PIX_W];
    assign idx_hi = idx + NA_W'(1);
    assign is_lin = (lin <= LIN_LIMIT);

    // Stage 1
    pix_t node_a_reg;
    pix_t node_b_reg;
    pix_t lin_val_reg;
    pix_t frac_reg;
    logic is_lin_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            node_a_reg  <= node_rom[idx];
            node_b_reg  <= node_rom[idx_hi];
            lin_val_reg <= lin_rom[lin[7:0]];
            frac_reg    <= t[PIX_W-1:0];
            is_lin_reg  <= is_lin;
        end
    end

    // Stage 2: base + round(diff * frac / 2^16)
    pix_t        base;
    pix_t        diff;
    logic [31:0] prod;
    logic [32:0] prod_rnd;
    logic [17:0] sum;
    pix_t        enc_next;
    pix_t        enc_reg;

    always_comb
    begin
        base     = is_lin_reg ? lin_val_reg : node_a_reg;
        diff     = is_lin_reg ? '0 : (node_b_reg - node_a_reg);
        prod     = 32'(diff) * 32'(frac_reg);
        prod_rnd = 33'(prod) + 33'd32768;
        sum      = 18'(base) + 18'(prod_rnd[32:16]);
        enc_next = (sum > 18'(NODE_SAT[PIX_W-1:0])) ? '1 : sum[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            enc_reg <= enc_next;
        end
    end

    assign enc = enc_reg;

endmodule

>>> hw/rtl/srgb_gamma_encode.sv
// ----------------------------------------------------------------------------
// srgb_gamma_encode: sRGB transfer function, linear Q0.16 to encoded Q0.16
// Pipeline: an accepted word passes two register stages (table read, then
//   interpolation) and leaves the second one with done high.
// Throughput: one pixel per clock; busy is never raised, the result path
//   has no back-pressure.
// Reset: rst_n clears only the stage valid flags; tables are constants.
// ----------------------------------------------------------------------------
module srgb_gamma_encode #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sge_pkg::pix_t lin_blue,
    input  sge_pkg::pix_t lin_green,
    input  sge_pkg::pix_t lin_red,
    output logic          done,
    output sge_pkg::pix_t enc_blue,
    output sge_pkg::pix_t enc_green,
    output sge_pkg::pix_t enc_red
);
    import sge_pkg::*;

    // Every cycle can take a new pixel; the pipeline never stalls.
    assign busy = 1'b0;

    logic       accept;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       done_reg;
    logic       done_next;
    stage_ctl_t ctl;

    assign accept        = start && !busy;
    assign s1_valid_next = accept;
    assign done_next     = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            done_reg     <= done_next;
        end
    end

    assign ctl.load    = accept;
    assign ctl.advance = s1_valid_reg;
    assign done        = done_reg;

    // Three independent channel datapaths
    sge_channel #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_blue (
        .clk (clk),
        .ctl (ctl),
        .lin (lin_blue),
        .enc (enc_blue)
    );

    sge_channel #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_green (
        .clk (clk),
        .ctl (ctl),
        .lin (lin_green),
        .enc (enc_green)
    );

    sge_channel #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_red (
        .clk (clk),
        .ctl (ctl),
        .lin (lin_red),
        .enc (enc_red)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Every accepted word yields a result once it has passed both register stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted word did not produce a result");

    // No result without a word accepted ahead of it through both register stages
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without an accepted word");

    // Red channel: linear segment result stays at or below its end point
    a_lin_red: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (lin_red <= LIN_LIMIT)) |=> ##1 (enc_red <= LIN_MAX))
        else $error("linear segment result out of range");

endmodule

>>> test/srgb_gamma_encode_tb.sv
// ----------------------------------------------------------------------------
// srgb_gamma_encode_tb: self-checking bench for the sRGB encoder
// Sends linear pixels through the command port with random idle gaps and
// compares every encoded word, channel by channel, against an in-bench
// integer model of the linear segment and the interpolated curve table.
// ----------------------------------------------------------------------------
module srgb_gamma_encode_tb;

    import sge_pkg::pix_t;

    localparam int NODES       = 256;        // curve table segments
    localparam int LINEAR_TOP  = 205;        // last code on the 12.92*x segment
    localparam int RANDOM_PIX  = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 10;         // settle time after the queues drain

    // one linear pixel waiting to be driven, with idle cycles ahead of it
    typedef struct {
        pix_t blue;
        pix_t green;
        pix_t red;
        int   gap;
    } lin_pixel_t;

    // one encoded pixel the block owes us
    typedef struct packed {
        pix_t blue;
        pix_t green;
        pix_t red;
    } enc_pixel_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    pix_t lin_blue  = '0;
    pix_t lin_green = '0;
    pix_t lin_red   = '0;
    logic busy;
    logic done;
    pix_t enc_blue;
    pix_t enc_green;
    pix_t enc_red;

    lin_pixel_t  lin_pixels_pending[$];
    enc_pixel_t  enc_pixels_due[$];
    logic [31:0] curve_nodes [0:NODES];

    int idle_cnt        = 0;
    int cycle_cnt       = 0;
    int error_cnt       = 0;
    int pixels_sent     = 0;
    int pixels_checked  = 0;
    int linear_channels = 0;
    int curve_channels  = 0;

    srgb_gamma_encode #(
        .TABLE_ENTRIES(NODES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .lin_blue (lin_blue),
        .lin_green(lin_green),
        .lin_red  (lin_red),
        .done     (done),
        .enc_blue (enc_blue),
        .enc_green(enc_green),
        .enc_red  (enc_red)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------

    // floor of the square root, or of the cube root when cube is set
    function automatic longint unsigned int_root(input longint unsigned v, input bit cube);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned pw;
        lo = 64'd0;
        hi = cube ? (64'd1 << 21) : (64'd1 << 31);
        while ((hi - lo) > 64'd1)
        begin
            mid = (lo + hi) >> 1;
            pw  = cube ? mid * mid * mid : mid * mid;
            if (pw <= v)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // one channel: 12.92*x near black, interpolated curve above the threshold
    function automatic pix_t gamma_encode_channel(input pix_t x);
        logic [31:0] t;
        logic [31:0] idx;
        logic [31:0] frac;
        logic [31:0] lo_n;
        logic [31:0] hi_n;
        logic [31:0] v;
        if (int'(x) <= LINEAR_TOP)
        begin
            v = (32'd323 * 32'(x) + 32'd12) / 32'd25;
            return v[15:0];
        end
        t    = 32'(x) * NODES;
        idx  = t >> 16;
        frac = t & 32'hFFFF;
        if (idx >= NODES)
        begin
            idx = NODES - 1;
        end
        lo_n = curve_nodes[idx];
        hi_n = curve_nodes[idx + 1];
        v    = lo_n + 32'(((64'(hi_n - lo_n) * 64'(frac)) + 64'd32768) >> 16);
        if (v > 32'd65535)
        begin
            v = 32'd65535;
        end
        return v[15:0];
    endfunction

    // mix of codes near the linear threshold, on table node edges and anywhere
    function automatic pix_t pick_level();
        int unsigned pick;
        int          near;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            return pix_t'($urandom_range(300));
        end
        if (pick < 40)
        begin
            near = int'($urandom_range(NODES)) * (65536 / NODES) + int'($urandom_range(4)) - 2;
            if (near < 0)
            begin
                near = 0;
            end
            if (near > 65535)
            begin
                near = 65535;
            end
            return pix_t'(near);
        end
        return pix_t'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input pix_t got, input pix_t want);
        $display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        error_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued pixels, honoring each one's idle gap.
    // A word is taken at an edge with start high and busy low; on
    // acceptance the encoded pixel it must produce is queued.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        lin_pixel_t nxt;
        enc_pixel_t due;
        if (!rst_n)
        begin
            start    <= 1'b0;
            idle_cnt <= 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                due.blue  = gamma_encode_channel(lin_blue);
                due.green = gamma_encode_channel(lin_green);
                due.red   = gamma_encode_channel(lin_red);
                enc_pixels_due.push_back(due);
                pixels_sent++;
                linear_channels += (int'(lin_blue) <= LINEAR_TOP)
                                 + (int'(lin_green) <= LINEAR_TOP)
                                 + (int'(lin_red) <= LINEAR_TOP);
            end
            if (lin_pixels_pending.size() > 0 && idle_cnt >= lin_pixels_pending[0].gap)
            begin
                nxt = lin_pixels_pending.pop_front();
                lin_blue  <= nxt.blue;
                lin_green <= nxt.green;
                lin_red   <= nxt.red;
                start     <= 1'b1;
                idle_cnt  <= 0;
            end
            else
            begin
                // idle cycle; scramble the data so a stale word is never reused
                start     <= 1'b0;
                lin_blue  <= pix_t'($urandom);
                lin_green <= pix_t'($urandom);
                lin_red   <= pix_t'($urandom);
                if (lin_pixels_pending.size() > 0)
                begin
                    idle_cnt <= idle_cnt + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done marks a one-cycle result word, no back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        enc_pixel_t want;
        if (rst_n && done)
        begin
            if (enc_pixels_due.size() == 0)
            begin
                report_mismatch("result with no pixel outstanding, blue", enc_blue, '0);
            end
            else
            begin
                want = enc_pixels_due.pop_front();
                if (enc_blue !== want.blue)
                begin
                    report_mismatch("enc_blue", enc_blue, want.blue);
                end
                if (enc_green !== want.green)
                begin
                    report_mismatch("enc_green", enc_green, want.green);
                end
                if (enc_red !== want.red)
                begin
                    report_mismatch("enc_red", enc_red, want.red);
                end
                pixels_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still owed",
                     cycle_cnt, enc_pixels_due.size());
            $display("srgb_gamma_encode_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        longint unsigned u;
        longint unsigned c;
        longint unsigned s;
        longint unsigned f;
        longint unsigned pos;
        longint unsigned q;
        int              gap;
        int unsigned     pick;

        // curve nodes: node k is 1.055*(k/NODES)^(1/2.4) - 0.055, built from
        // the same integer roots as the encoder's table: x^(5/12) = x^(1/3) * x^(1/12)
        for (int k = 0; k <= NODES; k++)
        begin
            u   = ((64'(k) << 48) / 64'(NODES)) << 12;
            c   = int_root(u, 1'b1);
            s   = int_root(c << 40, 1'b0);
            f   = int_root(s << 30, 1'b0);
            pos = 64'd211 * c * f;
            if (pos <= (64'd11 << 50))
            begin
                q = 64'd0;      // curve dips below zero at black
            end
            else
            begin
                q = (pos - (64'd11 << 50) + (64'd100 << 34)) / (64'd200 << 34);
                if (q > 64'd65535)
                begin
                    q = 64'd65535;
                end
            end
            curve_nodes[k] = q[31:0];
        end

        // directed: black, full scale, both sides of the linear threshold,
        // table node edges, last segment, alternating bit patterns
        lin_pixels_pending.push_back('{16'd0,     16'd0,     16'd0,     0});
        lin_pixels_pending.push_back('{16'd65535, 16'd65535, 16'd65535, 0});
        lin_pixels_pending.push_back('{16'd205,   16'd206,   16'd204,   0});
        lin_pixels_pending.push_back('{16'd206,   16'd205,   16'd1,     1});
        lin_pixels_pending.push_back('{16'd1,     16'd2,     16'd3,     0});
        lin_pixels_pending.push_back('{16'd0,     16'd65535, 16'd205,   0});
        lin_pixels_pending.push_back('{16'd65534, 16'd256,   16'd255,   2});
        lin_pixels_pending.push_back('{16'd257,   16'd511,   16'd512,   0});
        lin_pixels_pending.push_back('{16'h5555,  16'hAAAA,  16'h8000,  0});
        lin_pixels_pending.push_back('{16'hAAAA,  16'h5555,  16'h7FFF,  1});
        lin_pixels_pending.push_back('{16'h00FF,  16'hFF00,  16'h0F0F,  0});
        lin_pixels_pending.push_back('{16'd100,   16'd150,   16'd200,   0});
        lin_pixels_pending.push_back('{16'd207,   16'd208,   16'd300,   3});
        lin_pixels_pending.push_back('{16'd65280, 16'd65279, 16'd65281, 0});
        lin_pixels_pending.push_back('{16'd25,    16'd26,    16'd24,    0});
        lin_pixels_pending.push_back('{16'hFFFE,  16'h0001,  16'h8001,  0});

        // random: mostly short gaps, some long, and gap-free bursts
        for (int n = 0; n < RANDOM_PIX; n++)
        begin
            pick = $urandom_range(99);
            if ((n % 400) < 100 || pick < 55)
            begin
                gap = 0;
            end
            else if (pick < 88)
            begin
                gap = $urandom_range(3, 1);
            end
            else if (pick < 97)
            begin
                gap = $urandom_range(12, 4);
            end
            else
            begin
                gap = $urandom_range(60, 20);
            end
            lin_pixels_pending.push_back('{pick_level(), pick_level(), pick_level(), gap});
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sample at the falling edge so queue updates of the edge have settled
        do
        begin
            @(negedge clk);
        end
        while (lin_pixels_pending.size() != 0 || start || enc_pixels_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        curve_channels = 3 * pixels_sent - linear_channels;
        $display("srgb_gamma_encode_tb: %0d pixels sent, %0d encoded words checked",
                 pixels_sent, pixels_checked);
        $display("srgb_gamma_encode_tb: %0d channels on the linear segment, %0d on the curve",
                 linear_channels, curve_channels);
        if (error_cnt == 0)
        begin
            $display("srgb_gamma_encode_tb: done, clean");
        end
        else
        begin
            $display("%0d mismatches", error_cnt);
            $display("srgb_gamma_encode_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sge_pkg.sv
hw/rtl/sge_channel.sv
hw/rtl/srgb_gamma_encode.sv
test/srgb_gamma_encode_tb.sv
